@@ design/source_text_tokenizer_unit_macros.svh @@
// Assertion macros for the source text tokenizer.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef SOURCE_TEXT_TOKENIZER_UNIT_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_UNIT_MACROS_SVH

// checked only out of reset
`define STT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define STT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/stt_pkg.sv @@
// Shared types, token codes and lookup functions of the source text tokenizer.
// No dependencies.
package stt_pkg;

	localparam int SOURCE_BYTES_DEF = 65536;
	localparam int STRING_MAX_DEF   = 255;
	localparam int NAME_MAX_DEF     = 63;
	localparam logic [15:0] TOKEN_LIMIT_RESET = 16'd1024;
	localparam int QDEPTH = 4;

	// token codes
	localparam logic [5:0] K_NUMBER = 6'd19;
	localparam logic [5:0] K_IDENT  = 6'd20;
	localparam logic [5:0] K_STRING = 6'd21;
	localparam logic [5:0] K_EQEQ   = 6'd22;
	localparam logic [5:0] K_NEQ    = 6'd23;
	localparam logic [5:0] K_GTE    = 6'd24;
	localparam logic [5:0] K_LTE    = 6'd25;
	localparam logic [5:0] K_ARROW  = 6'd26;
	localparam logic [5:0] K_EQ     = 6'd27;
	localparam logic [5:0] K_PLUS   = 6'd28;
	localparam logic [5:0] K_MINUS  = 6'd29;
	localparam logic [5:0] K_STAR   = 6'd30;
	localparam logic [5:0] K_SLASH  = 6'd31;
	localparam logic [5:0] K_GT     = 6'd32;
	localparam logic [5:0] K_LT     = 6'd33;
	localparam logic [5:0] K_LPAREN = 6'd34;
	localparam logic [5:0] K_RPAREN = 6'd35;
	localparam logic [5:0] K_COMMA  = 6'd36;
	localparam logic [5:0] K_COLON  = 6'd37;
	localparam logic [5:0] K_EOF    = 6'd38;
	localparam logic [5:0] K_ERROR  = 6'd39;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_UNKNOWN  = 2'd1;
	localparam logic [1:0] ST_TOO_MANY = 2'd2;
	localparam logic [1:0] ST_TOO_LONG = 2'd3;

	// input item kinds
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// characters
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_UNDER  = 8'h5F;

	localparam int NUM_KW = 19;
	localparam int KW_PREFIX_BYTES = 6;

	// keyword text, first character in the low byte
	localparam logic [47:0] KW_TEXT [NUM_KW] = '{
		48'h0000_0074_656C, // let
		48'h0000_0000_6E66, // fn
		48'h6E72_7574_6572, // return
		48'h0000_0000_6669, // if
		48'h0000_6669_6C65, // elif
		48'h0000_6573_6C65, // else
		48'h0065_6C69_6877, // while
		48'h0000_0072_6F66, // for
		48'h0000_0000_6F74, // to
		48'h0000_7065_7473, // step
		48'h0000_0064_6E65, // end
		48'h0074_6E69_7270, // print
		48'h0000_0074_6E69, // int
		48'h0074_616F_6C66, // float
		48'h0000_0072_7473, // str
		48'h0000_0072_7470, // ptr
		48'h0000_6C6F_6F62, // bool
		48'h0000_6575_7274, // true
		48'h0065_736C_6166  // false
	};
	localparam logic [2:0] KW_LEN [NUM_KW] = '{
		3'd3, 3'd2, 3'd6, 3'd2, 3'd4, 3'd4, 3'd5, 3'd3, 3'd2, 3'd4,
		3'd3, 3'd5, 3'd3, 3'd5, 3'd3, 3'd3, 3'd4, 3'd4, 3'd5
	};

	typedef struct packed {
		logic [5:0]  kind;
		logic [15:0] start;
		logic [7:0]  length;
		logic [1:0]  status;
		logic        last;
	} word_t;

	// words handed from the lexer to the output queue in one cycle
	typedef struct packed {
		logic [1:0] n;
		word_t      w0;
		word_t      w1;
	} push_t;

	typedef struct packed {
		logic                      no_room;
		logic [$clog2(QDEPTH):0]   count;
	} qstat_t;

	function automatic logic [5:0] single_op_kind(input logic [7:0] c);
		logic [5:0] k;
		case (c)
			CH_EQ:     k = K_EQ;
			CH_PLUS:   k = K_PLUS;
			CH_MINUS:  k = K_MINUS;
			CH_STAR:   k = K_STAR;
			CH_SLASH:  k = K_SLASH;
			CH_GT:     k = K_GT;
			CH_LT:     k = K_LT;
			CH_LPAREN: k = K_LPAREN;
			CH_RPAREN: k = K_RPAREN;
			CH_COMMA:  k = K_COMMA;
			CH_COLON:  k = K_COLON;
			default:   k = K_ERROR;
		endcase
		return k;
	endfunction

	// two-character operator from held byte p and next byte c; K_ERROR if none
	function automatic logic [5:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
		logic [5:0] k;
		k = K_ERROR;
		if (c == CH_EQ) begin
			case (p)
				CH_EQ:   k = K_EQEQ;
				CH_BANG: k = K_NEQ;
				CH_GT:   k = K_GTE;
				CH_LT:   k = K_LTE;
				default: k = K_ERROR;
			endcase
		end else if (c == CH_GT && p == CH_MINUS) begin
			k = K_ARROW;
		end
		return k;
	endfunction

	function automatic logic [5:0] keyword_kind(input logic [47:0] prefix,
		input logic [8:0] len);
		logic [5:0] k;
		k = K_IDENT;
		for (int i = NUM_KW - 1; i >= 0; i--) begin
			if (len == 9'(KW_LEN[i]) && prefix == KW_TEXT[i])
				k = 6'(i);
		end
		return k;
	endfunction

endpackage

@@ design/source_text_tokenizer_unit.sv @@
// Top level of the source text tokenizer: config register, lexer front,
// result queue back. Depends on stt_pkg, stt_lexer, stt_queue and the macro header.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | kind, byte_value
//  out     | output    | out_valid / out_stall| token_kind, token_start, token_length,
//          |           |                      | status, last_of_run
//  cfg     | input     | cfg_we               | cfg_wdata (token limit)
//
// One input word a cycle while in_stall is low; each word yields 0, 1 or 2 result
// words, written into a four-entry queue in the cycle it is taken. The queue drains
// one word a cycle while out_stall is low. in_stall rises when fewer than two queue
// entries are free. Reset clears the scanner state and the queue and sets the token
// limit to 1024.
`include "source_text_tokenizer_unit_macros.svh"

module source_text_tokenizer_unit import stt_pkg::*; #(
	parameter int SOURCE_BYTES = SOURCE_BYTES_DEF,
	parameter int STRING_MAX   = STRING_MAX_DEF,
	parameter int NAME_MAX     = NAME_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [7:0]  byte_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  token_kind,
	output logic [15:0] token_start,
	output logic [7:0]  token_length,
	output logic [1:0]  status,
	output logic        last_of_run,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	logic [15:0] token_limit_q;
	logic        acc, pop;
	push_t       push;
	word_t       head;
	qstat_t      qstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			token_limit_q <= TOKEN_LIMIT_RESET;
		else if (cfg_we)
			token_limit_q <= cfg_wdata;
	end

	assign in_stall = qstat.no_room;
	assign acc      = in_valid && !in_stall;
	assign pop      = out_valid && !out_stall;

	stt_lexer #(
		.SOURCE_BYTES(SOURCE_BYTES),
		.STRING_MAX  (STRING_MAX),
		.NAME_MAX    (NAME_MAX)
	) u_lexer (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.kind       (kind),
		.byte_value (byte_value),
		.token_limit(token_limit_q),
		.push       (push)
	);

	stt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.pop      (pop),
		.head     (head),
		.not_empty(out_valid),
		.stat     (qstat)
	);

	assign token_kind   = head.kind;
	assign token_start  = head.start;
	assign token_length = head.length;
	assign status       = head.status;
	assign last_of_run  = head.last;

	`STT_ASSERT_ALWAYS(a_queue_bound, qstat.count <= ($clog2(QDEPTH)+1)'(QDEPTH), "queue count over depth")
	`STT_ASSERT(a_push_only_on_accept, (push.n != 2'd0) |-> acc, "words pushed without an accepted input")
	`STT_ASSERT(a_two_word_last, (push.n == 2'd2) |-> (push.w1.last && !push.w0.last), "last_of_run misplaced on a two-word push")
	`STT_ASSERT(a_error_status, out_valid |-> ((token_kind == K_ERROR) == (status != ST_OK)), "status and error code disagree")

endmodule

@@ design/stt_lexer.sv @@
// Front part: takes source words, runs the scanner state and produces up to
// two result words per input word. Depends on stt_pkg.
module stt_lexer import stt_pkg::*; #(
	parameter int SOURCE_BYTES = SOURCE_BYTES_DEF,
	parameter int STRING_MAX   = STRING_MAX_DEF,
	parameter int NAME_MAX     = NAME_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        acc,
	input  logic        kind,
	input  logic [7:0]  byte_value,
	input  logic [15:0] token_limit,
	output push_t       push
);

	localparam int PW = $clog2(SOURCE_BYTES) + 1;

	typedef enum logic [2:0] {
		M_IDLE, M_COMMENT, M_NUMBER, M_NAME, M_STRING, M_SKIP, M_PENDOP
	} mode_t;

	typedef struct packed {
		logic        vld;
		logic        err;
		logic [5:0]  kind;
		logic [15:0] start;
		logic [7:0]  len;
		logic [1:0]  status;
	} req_t;

	mode_t       mode_q, mode_d;
	logic [7:0]  pend_q, pend_d;
	logic [15:0] start_q, start_d;
	logic [8:0]  len_q, len_d;
	logic [47:0] prefix_q, prefix_d;
	logic [PW-1:0] pos_q, pos_d;
	logic [15:0] cnt_q, cnt_d;
	logic        err_q, err_d;

	logic [7:0]  c;
	logic [15:0] pos16;
	logic        is_digit, is_alpha, is_blank;
	logic [5:0]  sop, pair;
	logic [7:0]  capped;
	logic [8:0]  len_inc;

	// outcome of a byte met between tokens
	mode_t       ib_mode;
	logic [7:0]  ib_pend;
	logic [15:0] ib_start;
	logic [8:0]  ib_len;
	logic [47:0] ib_prefix;
	req_t        ib_req;

	req_t        fr_req;
	req_t        req_a, req_b;

	logic [15:0] cnt_a, cnt_b;
	logic        lat_a, lat_b, out_a, out_b;
	word_t       wa, wb;

	assign c     = byte_value;
	assign pos16 = 16'(pos_q);
	assign is_digit = (c >= "0") && (c <= "9");
	assign is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"))
		|| (c == CH_UNDER);
	assign is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
	assign sop    = single_op_kind(c);
	assign pair   = pair_kind(pend_q, c);
	assign capped = (len_q > 9'(NAME_MAX)) ? 8'(NAME_MAX) : len_q[7:0];
	assign len_inc = len_q + 9'd1;

	always_comb begin
		ib_mode   = M_IDLE;
		ib_pend   = pend_q;
		ib_start  = start_q;
		ib_len    = len_q;
		ib_prefix = prefix_q;
		ib_req    = '0;
		if (is_blank) begin
			ib_mode = M_IDLE;
		end else if (c == CH_HASH) begin
			ib_mode = M_COMMENT;
		end else if (is_digit) begin
			ib_mode  = M_NUMBER;
			ib_start = pos16;
			ib_len   = 9'd1;
		end else if (is_alpha) begin
			ib_mode   = M_NAME;
			ib_start  = pos16;
			ib_len    = 9'd1;
			ib_prefix = 48'(c);
		end else if (c == CH_QUOTE) begin
			ib_mode  = M_STRING;
			ib_start = pos16 + 16'd1;
			ib_len   = 9'd0;
		end else if (c == CH_EQ || c == CH_BANG || c == CH_GT || c == CH_LT
			|| c == CH_MINUS) begin
			ib_mode  = M_PENDOP;
			ib_pend  = c;
			ib_start = pos16;
		end else if (sop != K_ERROR) begin
			ib_req = '{vld: 1'b1, err: 1'b0, kind: sop, start: pos16, len: 8'd1,
				status: ST_OK};
		end else begin
			ib_req = '{vld: 1'b1, err: 1'b1, kind: K_ERROR, start: pos16, len: 8'd0,
				status: ST_UNKNOWN};
		end
	end

	// closing the run that is open, if any
	always_comb begin
		fr_req = '0;
		case (mode_q)
			M_NUMBER: fr_req = '{vld: 1'b1, err: 1'b0, kind: K_NUMBER, start: start_q,
				len: capped, status: ST_OK};
			M_NAME:   fr_req = '{vld: 1'b1, err: 1'b0,
				kind: keyword_kind(prefix_q, len_q), start: start_q, len: capped,
				status: ST_OK};
			M_STRING: fr_req = '{vld: 1'b1, err: 1'b0, kind: K_STRING, start: start_q,
				len: len_q[7:0], status: ST_OK};
			M_PENDOP: begin
				if (pend_q == CH_BANG)
					fr_req = '{vld: 1'b1, err: 1'b1, kind: K_ERROR, start: start_q,
						len: 8'd0, status: ST_UNKNOWN};
				else
					fr_req = '{vld: 1'b1, err: 1'b0, kind: single_op_kind(pend_q),
						start: start_q, len: 8'd1, status: ST_OK};
			end
			default: fr_req = '0;
		endcase
	end

	always_comb begin
		mode_d   = mode_q;
		pend_d   = pend_q;
		start_d  = start_q;
		len_d    = len_q;
		prefix_d = prefix_q;
		pos_d    = pos_q;
		req_a    = '0;
		req_b    = '0;
		if (kind == KIND_END) begin
			if (!err_q) begin
				req_a = fr_req;
				req_b = '{vld: 1'b1, err: 1'b0, kind: K_EOF, start: pos16, len: 8'd0,
					status: ST_OK};
			end
		end else if (!err_q) begin
			if (pos_q >= PW'(SOURCE_BYTES)) begin
				req_a = '{vld: 1'b1, err: 1'b1, kind: K_ERROR, start: pos16, len: 8'd0,
					status: ST_TOO_LONG};
			end else begin
				pos_d = pos_q + PW'(1);
				unique case (mode_q)
					M_COMMENT: begin
						if (c == CH_LF)
							mode_d = M_IDLE;
					end
					M_SKIP: mode_d = M_IDLE;
					M_STRING: begin
						if (c == CH_QUOTE) begin
							req_a  = fr_req;
							mode_d = M_IDLE;
						end else begin
							len_d = len_inc;
							if (len_inc >= 9'(STRING_MAX)) begin
								req_a = '{vld: 1'b1, err: 1'b0, kind: K_STRING,
									start: start_q, len: len_inc[7:0], status: ST_OK};
								mode_d = M_SKIP;
							end
						end
					end
					M_NUMBER, M_NAME: begin
						if (is_digit || (mode_q == M_NAME && is_alpha)) begin
							if (mode_q == M_NAME && len_q < 9'(KW_PREFIX_BYTES))
								prefix_d = prefix_q | (48'(c) << {len_q[2:0], 3'b000});
							if (len_q != 9'h1FF)
								len_d = len_inc;
						end else begin
							req_a    = fr_req;
							req_b    = ib_req;
							mode_d   = ib_mode;
							pend_d   = ib_pend;
							start_d  = ib_start;
							len_d    = ib_len;
							prefix_d = ib_prefix;
						end
					end
					M_PENDOP: begin
						if (pair != K_ERROR) begin
							req_a = '{vld: 1'b1, err: 1'b0, kind: pair, start: start_q,
								len: 8'd2, status: ST_OK};
							mode_d = M_IDLE;
						end else begin
							req_a    = fr_req;
							req_b    = ib_req;
							mode_d   = ib_mode;
							pend_d   = ib_pend;
							start_d  = ib_start;
							len_d    = ib_len;
							prefix_d = ib_prefix;
						end
					end
					default: begin
						req_b    = ib_req;
						mode_d   = ib_mode;
						pend_d   = ib_pend;
						start_d  = ib_start;
						len_d    = ib_len;
						prefix_d = ib_prefix;
					end
				endcase
			end
		end
	end

	// token budget and error latch, applied to the two requests in order
	always_comb begin
		cnt_a = cnt_q;
		lat_a = 1'b0;
		out_a = 1'b0;
		wa    = '0;
		if (req_a.vld) begin
			out_a    = 1'b1;
			wa.start = req_a.start;
			if (req_a.err) begin
				wa.kind   = K_ERROR;
				wa.status = req_a.status;
				lat_a     = 1'b1;
			end else if (cnt_q >= token_limit) begin
				wa.kind   = K_ERROR;
				wa.status = ST_TOO_MANY;
				lat_a     = 1'b1;
			end else begin
				wa.kind   = req_a.kind;
				wa.length = req_a.len;
				wa.status = ST_OK;
				cnt_a     = cnt_q + 16'd1;
			end
		end
		cnt_b = cnt_a;
		lat_b = lat_a;
		out_b = 1'b0;
		wb    = '0;
		if (req_b.vld && !lat_a) begin
			out_b    = 1'b1;
			wb.start = req_b.start;
			if (req_b.err) begin
				wb.kind   = K_ERROR;
				wb.status = req_b.status;
				lat_b     = 1'b1;
			end else if (cnt_a >= token_limit) begin
				wb.kind   = K_ERROR;
				wb.status = ST_TOO_MANY;
				lat_b     = 1'b1;
			end else begin
				wb.kind   = req_b.kind;
				wb.length = req_b.len;
				wb.status = ST_OK;
				cnt_b     = cnt_a + 16'd1;
			end
		end
		if (kind == KIND_END) begin
			cnt_d = '0;
			err_d = 1'b0;
		end else begin
			cnt_d = cnt_b;
			err_d = err_q | lat_b;
		end
	end

	always_comb begin
		push = '0;
		if (acc) begin
			if (out_a) begin
				push.w0      = wa;
				push.w0.last = !out_b;
				push.w1      = wb;
				push.w1.last = 1'b1;
				push.n       = out_b ? 2'd2 : 2'd1;
			end else if (out_b) begin
				push.w0      = wb;
				push.w0.last = 1'b1;
				push.n       = 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			pend_q   <= '0;
			start_q  <= '0;
			len_q    <= '0;
			prefix_q <= '0;
			pos_q    <= '0;
			cnt_q    <= '0;
			err_q    <= 1'b0;
		end else if (acc) begin
			cnt_q <= cnt_d;
			err_q <= err_d;
			if (kind == KIND_END) begin
				mode_q   <= M_IDLE;
				pend_q   <= '0;
				start_q  <= '0;
				len_q    <= '0;
				prefix_q <= '0;
				pos_q    <= '0;
			end else begin
				mode_q   <= mode_d;
				pend_q   <= pend_d;
				start_q  <= start_d;
				len_q    <= len_d;
				prefix_q <= prefix_d;
				pos_q    <= pos_d;
			end
		end
	end

endmodule

@@ design/stt_queue.sv @@
// Back part: result word queue; takes up to two words a cycle and
// gives one a cycle to the output channel on pop. Depends on stt_pkg.
module stt_queue import stt_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  push_t  push,
	input  logic   pop,
	output word_t  head,
	output logic   not_empty,
	output qstat_t stat
);

	localparam int AW = $clog2(QDEPTH);

	word_t           mem [QDEPTH];
	logic [AW-1:0]   wr_q, rd_q;
	logic [AW:0]     count_q;

	assign head         = mem[rd_q];
	assign not_empty    = (count_q != '0);
	assign stat.count   = count_q;
	// front may only go on while two free slots remain
	assign stat.no_room = (count_q > (AW+1)'(QDEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.n != 2'd0)
			mem[wr_q] <= push.w0;
		if (push.n == 2'd2)
			mem[wr_q + AW'(1)] <= push.w1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + AW'(push.n);
			rd_q    <= rd_q + AW'(pop);
			count_q <= count_q + (AW+1)'(push.n) - (AW+1)'(pop);
		end
	end

endmodule
